// ----- src/tcw_pkg.sv -----
// shared types and constants for the text console writer
// used by tcw_ctrl, tcw_datapath and text_console_writer; no dependencies
package tcw_pkg;

  localparam int OP_W     = 2;
  localparam int CH_W     = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CURSOR_W = 11;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [OP_W-1:0] OP_CHAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CH_W-1:0] ATTR_NORMAL  = 8'h07;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_DRAIN,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_ERASE,
    ST_PUT,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_SCROLL_START,
    CMD_CLEAR_START,
    CMD_SWEEP_STEP,
    CMD_ERASE,
    CMD_PUT,
    CMD_PLACE,
    CMD_READ,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_newline;
    logic            is_backspace;
    logic            nl_scroll;
    logic            at_end;
    logic            sweep_last;
    logic            out_free;
  } stat_t;

endpackage

// ----- src/tcw_ctrl.sv -----
// controller state machine for the text console writer
// depends on tcw_pkg; drives commands into tcw_datapath
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    ctrl_o.cmd = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        ctrl_o.cmd = CMD_SWEEP_STEP;
        if (stat_i.sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last pipelined sweep write lands here
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (stat_i.op == OP_CHAR && !stat_i.is_newline) begin
          state_d = ST_PUT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LATCH;
          pend_d     = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.op)
          OP_CHAR: begin
            if (stat_i.is_newline) begin
              ctrl_o.cmd = CMD_NEWLINE;
              state_d    = stat_i.nl_scroll ? ST_SCROLL : ST_DONE;
            end else if (stat_i.is_backspace) begin
              ctrl_o.cmd = CMD_BACKSPACE;
              state_d    = ST_ERASE;
            end else begin
              state_d = stat_i.at_end ? ST_SCROLL : ST_PUT;
            end
          end
          OP_CLEAR: begin
            ctrl_o.cmd = CMD_CLEAR_START;
            state_d    = ST_SWEEP;
          end
          OP_PLACE: begin
            ctrl_o.cmd = CMD_PLACE;
            state_d    = ST_DONE;
          end
          OP_READ: begin
            ctrl_o.cmd = CMD_READ;
            state_d    = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        ctrl_o.cmd = CMD_SCROLL_START;
        state_d    = ST_SWEEP;
      end
      ST_ERASE: begin
        ctrl_o.cmd = CMD_ERASE;
        state_d    = ST_DONE;
      end
      ST_PUT: begin
        ctrl_o.cmd = CMD_PUT;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_FINISH;
          pend_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/tcw_datapath.sv -----
// datapath of the text console writer: cell store, cursor, sweep engine, result register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [CH_W-1:0]     ch_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [COL_W-1:0]    column_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_W-1:0]     cell_char_o,
  output logic [CH_W-1:0]     cell_attr_o,
  output logic [CURSOR_W-1:0] cursor_o,
  output logic                scrolled_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 2);
  localparam int CW    = $clog2(COLUMNS);
  localparam int LW    = $clog2((ROWS + 1) * COLUMNS + 1);

  // character bytes only: every cell carries the normal attribute
  logic [CH_W-1:0] mem [CELLS];

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [CH_W-1:0] mem_wdata;
  logic [CH_W-1:0] rd_q;

  // latched item
  logic [OP_W-1:0] op_q;
  logic [CH_W-1:0] ch_q;
  logic [AW-1:0]   addr_q;
  logic            in_range_q;

  // cursor kept as row, column and linear position
  logic [RW-1:0] crow_q, crow_d;
  logic [CW-1:0] ccol_q, ccol_d;
  logic [LW-1:0] lin_q, lin_d;
  logic          scrolled_q, scrolled_d;

  // sweep engine, each write lands in the cycle after its read
  logic [AW-1:0] cnt_q, cnt_d;
  logic          blank_mode_q, blank_mode_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_blank_q, wr_blank_d;

  logic                out_valid_q, out_valid_d;
  logic [CH_W-1:0]     out_char_q, out_attr_q;
  logic [CURSOR_W-1:0] out_cursor_q;
  logic                out_scrolled_q;

  logic copy_src;
  logic rd_hit;

  assign copy_src = cnt_q < AW'(CELLS - COLUMNS);
  assign rd_hit   = (op_q == OP_READ) && in_range_q;

  always_comb begin
    stat_o.op           = op_q;
    stat_o.is_newline   = ch_q == CH_NEWLINE;
    stat_o.is_backspace = ch_q == CH_BACKSPACE;
    stat_o.nl_scroll    = crow_q >= RW'(ROWS - 1);
    stat_o.at_end       = crow_q >= RW'(ROWS);
    stat_o.sweep_last   = cnt_q == AW'(CELLS - 1);
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_comb begin
    crow_d       = crow_q;
    ccol_d       = ccol_q;
    lin_d        = lin_q;
    scrolled_d   = scrolled_q;
    cnt_d        = cnt_q;
    blank_mode_d = blank_mode_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = cnt_q;
    wr_blank_d   = 1'b1;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_waddr    = lin_q[AW-1:0];
    mem_wdata    = CH_SPACE;
    mem_re       = 1'b0;
    mem_raddr    = cnt_q + AW'(COLUMNS);

    if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = wr_blank_q ? CH_SPACE : rd_q;
    end

    case (ctrl_i.cmd)
      CMD_LATCH: scrolled_d = 1'b0;
      CMD_NEWLINE: begin
        lin_d  = lin_q - LW'(ccol_q) + LW'(COLUMNS);
        crow_d = crow_q + RW'(1);
        ccol_d = '0;
      end
      CMD_BACKSPACE: begin
        if (lin_q != '0) begin
          lin_d = lin_q - LW'(1);
          if (ccol_q != '0) begin
            ccol_d = ccol_q - CW'(1);
          end else begin
            ccol_d = CW'(COLUMNS - 1);
            crow_d = crow_q - RW'(1);
          end
        end
      end
      CMD_SCROLL_START: begin
        cnt_d        = '0;
        blank_mode_d = 1'b0;
        scrolled_d   = 1'b1;
        if (crow_q != '0) begin
          crow_d = crow_q - RW'(1);
          lin_d  = lin_q - LW'(COLUMNS);
        end else begin
          crow_d = '0;
          ccol_d = '0;
          lin_d  = '0;
        end
      end
      CMD_CLEAR_START: begin
        cnt_d        = '0;
        blank_mode_d = 1'b1;
        crow_d       = '0;
        ccol_d       = '0;
        lin_d        = '0;
      end
      CMD_SWEEP_STEP: begin
        cnt_d      = cnt_q + AW'(1);
        wr_pend_d  = 1'b1;
        wr_blank_d = blank_mode_q || !copy_src;
        mem_re     = !blank_mode_q && copy_src;
      end
      CMD_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = lin_q[AW-1:0];
        mem_wdata = CH_SPACE;
      end
      CMD_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = lin_q[AW-1:0];
        mem_wdata = ch_q;
        lin_d     = lin_q + LW'(1);
        if (ccol_q == CW'(COLUMNS - 1)) begin
          ccol_d = '0;
          crow_d = crow_q + RW'(1);
        end else begin
          ccol_d = ccol_q + CW'(1);
        end
      end
      CMD_PLACE: begin
        mem_we    = in_range_q;
        mem_waddr = addr_q;
        mem_wdata = ch_q;
      end
      CMD_READ: begin
        mem_re    = in_range_q;
        mem_raddr = addr_q;
      end
      CMD_FINISH: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crow_q       <= '0;
      ccol_q       <= '0;
      lin_q        <= '0;
      scrolled_q   <= 1'b0;
      cnt_q        <= '0;
      blank_mode_q <= 1'b1;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      crow_q       <= crow_d;
      ccol_q       <= ccol_d;
      lin_q        <= lin_d;
      scrolled_q   <= scrolled_d;
      cnt_q        <= cnt_d;
      blank_mode_q <= blank_mode_d;
      wr_pend_q    <= wr_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    wr_blank_q <= wr_blank_d;
    if (ctrl_i.cmd == CMD_LATCH) begin
      op_q       <= op_i;
      ch_q       <= ch_i;
      in_range_q <= (32'(row_i) < ROWS) && (32'(column_i) < COLUMNS);
      addr_q     <= AW'(32'(row_i) * COLUMNS + 32'(column_i));
    end
    if (ctrl_i.cmd == CMD_FINISH) begin
      out_char_q     <= rd_hit ? rd_q : '0;
      out_attr_q     <= rd_hit ? ATTR_NORMAL : '0;
      out_cursor_q   <= CURSOR_W'(lin_q);
      out_scrolled_q <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_char_o = out_char_q;
  assign cell_attr_o = out_attr_q;
  assign cursor_o    = out_cursor_q;
  assign scrolled_o  = out_scrolled_q;

endmodule

// ----- src/text_console_writer.sv -----
// sequence: place, read and newline go from decode to done, ordinary characters through put
// and backspace through erase; a scroll adds a sweep and drain pass and a clear screen is
// such a pass, the sweep moving one cell per cycle through the cell store
// throughput: one item at a time, next item accepted once the result sits in the output register
// reset: rst_ni clears control at once, then a clearing pass over every cell blanks
// the store while no item is accepted
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [CH_W-1:0]     ch_i,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [COL_W-1:0]    column_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CH_W-1:0]     cell_char_o,
  output logic [CH_W-1:0]     cell_attr_o,
  output logic [CURSOR_W-1:0] cursor_o,
  output logic                scrolled_o
);

  ctrl_t ctrl;
  stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .op_i        (op_i),
    .ch_i        (ch_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_char_o (cell_char_o),
    .cell_attr_o (cell_attr_o),
    .cursor_o    (cursor_o),
    .scrolled_o  (scrolled_o)
  );

endmodule
